// ===== rtl/core/length_prefixed_produce_parser_top_defines.svh =====
// assertion macros used by the parser checker
`ifndef LENGTH_PREFIXED_PRODUCE_PARSER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_PRODUCE_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LPP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpp check failed: same-cycle rule");

// next-cycle implication, disabled while reset is low
`define LPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpp check failed: next-cycle rule");

`endif

// ===== rtl/core/lpp_pkg.sv =====
// shared types and constants of the length-prefixed produce parser
package lpp_pkg;

    // hard caps on the frame and record length limits
    localparam logic [26:0] FRAME_CAP  = 27'd67108864;
    localparam logic [24:0] RECORD_CAP = 25'd16777216;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_FRAME_LEN  = 2'd0;
    localparam logic [1:0] CFG_MAX_RECORD_LEN = 2'd1;
    localparam logic [1:0] CFG_PRODUCE_TYPE   = 2'd2;

    // result kind codes
    localparam logic [2:0] KIND_LEN    = 3'd0;
    localparam logic [2:0] KIND_TYPE   = 3'd1;
    localparam logic [2:0] KIND_OPAQUE = 3'd2;
    localparam logic [2:0] KIND_HDR    = 3'd3;
    localparam logic [2:0] KIND_TOPIC  = 3'd4;
    localparam logic [2:0] KIND_RLEN   = 3'd5;
    localparam logic [2:0] KIND_KEY    = 3'd6;
    localparam logic [2:0] KIND_VAL    = 3'd7;

    // effective limits and produce type handed to the parser core
    typedef struct packed {
        logic [26:0] frame_lim;
        logic [24:0] rec_lim;
        logic [7:0]  produce_type;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic [7:0]  frame_type;
        logic        frame_end;
        logic        body_bad;
        logic        record_end;
        logic [24:0] key_len;
        logic [24:0] value_size;
        logic [15:0] topic_size;
        logic [31:0] partition;
        logic [31:0] record_count;
        logic        stream_error;
    } t_result;

endpackage

// ===== rtl/core/lpp_in_if.sv =====
// input byte channel: valid, ready and the stream byte
interface lpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/lpp_out_if.sv =====
// result channel: valid, ready and the decoded byte with its context
interface lpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic        frame_end;
    logic        body_bad;
    logic        record_end;
    logic [24:0] key_len;
    logic [24:0] value_size;
    logic [15:0] topic_size;
    logic [31:0] partition;
    logic [31:0] record_count;
    logic        stream_error;

    modport source (
        output valid, kind, out_byte, frame_type, frame_end, body_bad, record_end,
        output key_len, value_size, topic_size, partition, record_count, stream_error,
        input ready
    );
    modport sink (
        input valid, kind, out_byte, frame_type, frame_end, body_bad, record_end,
        input key_len, value_size, topic_size, partition, record_count, stream_error,
        output ready
    );
endinterface

// ===== rtl/core/lpp_core.sv =====
// frame and produce-body parser state with its per-byte next-state logic
module lpp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  lpp_pkg::t_cfg     i_cfg,
    output lpp_pkg::t_result  o_res
);
    import lpp_pkg::*;

    typedef enum logic [3:0] {
        PH_LEN    = 4'd0,
        PH_TYPE   = 4'd1,
        PH_OPAQUE = 4'd2,
        PH_TLEN   = 4'd3,
        PH_TOPIC  = 4'd4,
        PH_PART   = 4'd5,
        PH_COUNT  = 4'd6,
        PH_RLEN   = 4'd7,
        PH_KEY    = 4'd8,
        PH_VAL    = 4'd9,
        PH_SKIP   = 4'd10
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [2:0]  r_idx, n_idx;
    logic [26:0] r_frame_left, n_frame_left;
    logic [24:0] r_span, n_span;
    logic [7:0]  r_type, n_type;
    logic [24:0] r_key, n_key;
    logic [24:0] r_val, n_val;
    logic [15:0] r_topic, n_topic;
    logic [31:0] r_part, n_part;
    logic [31:0] r_count, n_count;
    logic        r_mal, n_mal;
    logic        r_broken, n_broken;

    logic [31:0] w_shifted;
    logic [2:0]  w_idx_inc;
    logic [24:0] w_span_dec;
    logic [26:0] w_frame_dec;
    logic        w_framed;
    logic        w_mal_now;
    logic [2:0]  w_kind;
    logic        w_fend, w_bad, w_rend;

    assign w_shifted   = {r_shift[23:0], i_byte};
    assign w_idx_inc   = r_idx + 3'd1;
    assign w_span_dec  = (r_span != '0) ? r_span - 25'd1 : '0;
    assign w_frame_dec = (r_frame_left != '0) ? r_frame_left - 27'd1 : '0;

    // next state and result for the byte being stepped
    always_comb begin
        n_phase      = r_phase;
        n_shift      = r_shift;
        n_idx        = r_idx;
        n_frame_left = r_frame_left;
        n_span       = r_span;
        n_type       = r_type;
        n_key        = r_key;
        n_val        = r_val;
        n_topic      = r_topic;
        n_part       = r_part;
        n_count      = r_count;
        n_mal        = r_mal;
        n_broken     = r_broken;
        w_framed     = 1'b1;
        w_mal_now    = r_mal;
        w_kind       = KIND_LEN;
        w_fend       = 1'b0;
        w_bad        = 1'b0;
        w_rend       = 1'b0;

        if (!r_broken) begin
            case (r_phase)
                PH_LEN: begin
                    w_framed = 1'b0;
                    n_shift  = w_shifted;
                    n_idx    = w_idx_inc;
                    if (w_idx_inc >= 3'd4) begin
                        n_idx   = '0;
                        n_shift = '0;
                        if (w_shifted == '0 || w_shifted > {5'd0, i_cfg.frame_lim}) begin
                            n_broken = 1'b1;
                        end else begin
                            n_frame_left = w_shifted[26:0];
                            n_phase      = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    w_kind = KIND_TYPE;
                    n_type = i_byte;
                    if (i_byte == i_cfg.produce_type) begin
                        n_phase = PH_TLEN;
                        n_key   = '0;
                        n_val   = '0;
                        n_topic = '0;
                        n_part  = '0;
                        n_count = '0;
                        n_mal   = 1'b0;
                        n_idx   = '0;
                        n_shift = '0;
                    end else begin
                        n_phase = PH_OPAQUE;
                    end
                end
                PH_TLEN: begin
                    w_kind  = KIND_HDR;
                    n_shift = w_shifted;
                    n_idx   = w_idx_inc;
                    if (w_idx_inc >= 3'd2) begin
                        n_topic = w_shifted[15:0];
                        n_idx   = '0;
                        n_shift = '0;
                        n_span  = {9'd0, w_shifted[15:0]};
                        n_phase = (w_shifted[15:0] != '0) ? PH_TOPIC : PH_PART;
                    end
                end
                PH_TOPIC: begin
                    w_kind = KIND_TOPIC;
                    n_span = w_span_dec;
                    if (w_span_dec == '0) begin
                        n_phase = PH_PART;
                    end
                end
                PH_PART, PH_COUNT: begin
                    w_kind  = KIND_HDR;
                    n_shift = w_shifted;
                    n_idx   = w_idx_inc;
                    if (w_idx_inc >= 3'd4) begin
                        if (r_phase == PH_PART) begin
                            n_part  = w_shifted;
                            n_phase = PH_COUNT;
                        end else begin
                            n_count = w_shifted;
                            n_phase = PH_RLEN;
                        end
                        n_idx   = '0;
                        n_shift = '0;
                    end
                end
                PH_RLEN: begin
                    w_kind  = KIND_RLEN;
                    n_shift = w_shifted;
                    n_idx   = w_idx_inc;
                    if (w_idx_inc == 3'd4) begin
                        // key length word complete
                        if (w_shifted > {7'd0, i_cfg.rec_lim}) begin
                            n_mal = 1'b1;
                        end
                        n_key   = w_shifted[24:0];
                        n_shift = '0;
                    end else if (w_idx_inc == 3'd0) begin
                        // value length word complete, pick the next span
                        w_mal_now = r_mal | (w_shifted > {7'd0, i_cfg.rec_lim});
                        n_mal     = w_mal_now;
                        n_val     = w_shifted[24:0];
                        n_shift   = '0;
                        if (w_mal_now) begin
                            n_phase = PH_SKIP;
                        end else if (r_key != '0) begin
                            n_span  = r_key;
                            n_phase = PH_KEY;
                        end else if (w_shifted[24:0] != '0) begin
                            n_span  = w_shifted[24:0];
                            n_phase = PH_VAL;
                        end else begin
                            w_rend  = 1'b1;
                            n_phase = PH_RLEN;
                        end
                    end
                end
                PH_KEY: begin
                    w_kind = KIND_KEY;
                    n_span = w_span_dec;
                    if (w_span_dec == '0) begin
                        if (r_val != '0) begin
                            n_span  = r_val;
                            n_phase = PH_VAL;
                        end else begin
                            w_rend  = 1'b1;
                            n_phase = PH_RLEN;
                        end
                    end
                end
                PH_VAL: begin
                    w_kind = KIND_VAL;
                    n_span = w_span_dec;
                    if (w_span_dec == '0) begin
                        w_rend  = 1'b1;
                        n_phase = PH_RLEN;
                    end
                end
                default: begin
                    w_kind = KIND_OPAQUE;
                end
            endcase

            // frame byte count and end-of-frame verdict
            if (w_framed) begin
                n_frame_left = w_frame_dec;
                if (w_frame_dec == '0) begin
                    w_fend = 1'b1;
                    if (n_phase != PH_OPAQUE) begin
                        w_bad = n_mal || !(n_phase == PH_RLEN && n_idx == 3'd0);
                    end
                    n_phase = PH_LEN;
                    n_idx   = '0;
                    n_shift = '0;
                    n_span  = '0;
                end
            end
        end
    end

    // result for this byte, taken from the updated state
    always_comb begin
        o_res.kind         = w_kind;
        o_res.out_byte     = i_byte;
        o_res.frame_type   = n_type;
        o_res.frame_end    = w_fend;
        o_res.body_bad     = w_bad;
        o_res.record_end   = w_rend;
        o_res.key_len      = n_key;
        o_res.value_size   = n_val;
        o_res.topic_size   = n_topic;
        o_res.partition    = n_part;
        o_res.record_count = n_count;
        o_res.stream_error = n_broken;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN;
            r_shift      <= '0;
            r_idx        <= '0;
            r_frame_left <= '0;
            r_span       <= '0;
            r_type       <= '0;
            r_key        <= '0;
            r_val        <= '0;
            r_topic      <= '0;
            r_part       <= '0;
            r_count      <= '0;
            r_mal        <= 1'b0;
            r_broken     <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_idx        <= n_idx;
            r_frame_left <= n_frame_left;
            r_span       <= n_span;
            r_type       <= n_type;
            r_key        <= n_key;
            r_val        <= n_val;
            r_topic      <= n_topic;
            r_part       <= n_part;
            r_count      <= n_count;
            r_mal        <= n_mal;
            r_broken     <= n_broken;
        end
    end

endmodule

// ===== rtl/core/length_prefixed_produce_parser_top.sv =====
// top level of the length-prefixed produce parser: channels, config and pipeline
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------
//   i_in     | in  | valid/ready  | in_byte
//   o_out    | out | valid/ready  | kind, out_byte, frame context, held fields
//   i_cfg_*  | in  | write enable | register index, 27-bit write data
//
// one byte per cycle sustained while results are taken; each accepted request goes
// through the input register, then the parse step into the result register
// the parse step is a single pass over the parser state, updated once per byte
// reset is synchronous and immediate; no clearing pass, no memories
// a stalled result holds in the output register while one more byte waits
// in the input register
module length_prefixed_produce_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpp_in_if.sink       i_in,
    lpp_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [26:0]  i_cfg_data
);
    import lpp_pkg::*;

    logic [26:0] r_frame_lim;
    logic [24:0] r_rec_lim;
    logic [7:0]  r_ptype;
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_out_valid;
    t_result     r_out;

    t_cfg        w_cfg;
    t_result     w_res;
    logic        w_out_adv;
    logic        w_step;

    // config registers hold the effective limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_lim <= FRAME_CAP;
            r_rec_lim   <= RECORD_CAP;
            r_ptype     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_FRAME_LEN: begin
                    r_frame_lim <= (i_cfg_data > FRAME_CAP) ? FRAME_CAP : i_cfg_data;
                end
                CFG_MAX_RECORD_LEN: begin
                    r_rec_lim <= (i_cfg_data[24:0] > RECORD_CAP) ? RECORD_CAP
                                                                : i_cfg_data[24:0];
                end
                CFG_PRODUCE_TYPE: begin
                    r_ptype <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.frame_lim    = r_frame_lim;
    assign w_cfg.rec_lim      = r_rec_lim;
    assign w_cfg.produce_type = r_ptype;

    // pipeline flow control
    assign w_out_adv  = !r_out_valid || o_out.ready;
    assign w_step     = r_s1_valid && w_out_adv;
    assign i_in.ready = !r_s1_valid || w_step;

    lpp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_s1_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_s1_valid <= 1'b1;
                r_s1_byte  <= i_in.in_byte;
            end else if (w_step) begin
                r_s1_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result port
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.out_byte     = r_out.out_byte;
    assign o_out.frame_type   = r_out.frame_type;
    assign o_out.frame_end    = r_out.frame_end;
    assign o_out.body_bad     = r_out.body_bad;
    assign o_out.record_end   = r_out.record_end;
    assign o_out.key_len      = r_out.key_len;
    assign o_out.value_size   = r_out.value_size;
    assign o_out.topic_size   = r_out.topic_size;
    assign o_out.partition    = r_out.partition;
    assign o_out.record_count = r_out.record_count;
    assign o_out.stream_error = r_out.stream_error;

endmodule

// ===== rtl/core/lpp_checker.sv =====
// port-level checks on the parser top, attached by bind
`include "length_prefixed_produce_parser_top_defines.svh"

module lpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [7:0]  i_out_byte,
    input logic        i_frame_end,
    input logic        i_body_bad,
    input logic        i_record_end,
    input logic        i_stream_error
);
    import lpp_pkg::*;

    // a broken stream reports only length bytes and never ends a frame
    `LPP_ASSERT_IMPLY(a_err_quiet, i_clk, i_rst_n, i_out_valid && i_stream_error, i_kind == KIND_LEN && !i_frame_end)

    // a bad body is only flagged on the last byte of a frame
    `LPP_ASSERT_IMPLY(a_bad_at_end, i_clk, i_rst_n, i_out_valid && i_body_bad, i_frame_end)

    // a record ends only on a length, key or value byte
    `LPP_ASSERT_IMPLY(a_rend_kind, i_clk, i_rst_n, i_out_valid && i_record_end, i_kind == KIND_RLEN || i_kind == KIND_KEY || i_kind == KIND_VAL)

    // a stalled result stays put
    `LPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_kind))

endmodule

bind length_prefixed_produce_parser_top lpp_checker u_lpp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_out_byte     (o_out.out_byte),
    .i_frame_end    (o_out.frame_end),
    .i_body_bad     (o_out.body_bad),
    .i_record_end   (o_out.record_end),
    .i_stream_error (o_out.stream_error)
);
